// ----- rtl/bb3_pkg.sv -----
package bb3_pkg;

  // fixed field widths
  localparam int DIM_W      = 11;
  localparam int DIM_MAX    = (1 << DIM_W) - 1;
  localparam int POS_W      = DIM_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int NUM_W      = SUM_W + 1;
  localparam int RECIP_W    = 16;

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // register reset values
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // input word kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // reciprocals for exact floor division by 3 and 9 (numerator < 2^13)
  localparam logic [RECIP_W-1:0] RECIP3 = 16'd43691;
  localparam logic [RECIP_W-1:0] RECIP9 = 16'd58255;
  localparam int SHIFT3 = 17;
  localparam int SHIFT9 = 19;

  // position flags of one input word
  typedef struct packed {
    logic emit;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } pos_flags_t;

  // per-channel sums and divisor code of one result
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       pow2;
    logic [1:0]       pow3;
    logic             last;
  } sum_word_t;

  // (2*sum + cnt) / (2*cnt), divisor = 2^pow2 * 3^pow3
  function automatic logic [CHAN_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                    input logic [CNT_W-1:0] cnt,
                                                    input logic [1:0]       pow2,
                                                    input logic [1:0]       pow3);
    logic [NUM_W-1:0]         num;
    logic [NUM_W-1:0]         part;
    logic [RECIP_W-1:0]       recip;
    logic [NUM_W+RECIP_W-1:0] prod;
    logic [NUM_W-1:0]         q;
    num   = {sum, 1'b0} + NUM_W'(cnt);
    part  = num >> pow2;
    recip = (pow3 == 2'd2) ? RECIP9 : RECIP3;
    prod  = (NUM_W+RECIP_W)'(part) * (NUM_W+RECIP_W)'(recip);
    case (pow3)
      2'd1:    q = NUM_W'(prod >> SHIFT3);
      2'd2:    q = NUM_W'(prod >> SHIFT9);
      default: q = part;
    endcase
    return q[CHAN_W-1:0];
  endfunction

endpackage

// ----- rtl/bb3_if.sv -----
// input channel: one pixel or drain word
interface bb3_in_if import bb3_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;

  modport source (output valid, func, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

// result channel: one blurred pixel
interface bb3_out_if import bb3_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              last_pixel;

  modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface

// ----- rtl/bb3_ram.sv -----
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bb3_raster.sv -----
module bb3_raster import bb3_pkg::*; #(
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [POS_W-1:0]  width,
  input  logic [POS_W-1:0]  height,
  output logic [ADDR_W-1:0] x,
  output pos_flags_t        flags
);

  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic              done_r, done_nxt;

  logic [POS_W-1:0]  c0, xw, xn, ccw, ccp1, crp1;
  logic [DIM_W-1:0]  r0, y, cr;
  logic              xpos;

  // position of this word, its center pixel and the next position
  always_comb begin
    c0 = done_r ? '0 : POS_W'(col_r);
    r0 = done_r ? '0 : row_r;
    // column beyond a narrowed width wraps to the next row
    if (c0 >= width) begin
      xw = '0;
      y  = r0 + DIM_W'(1);
    end else begin
      xw = c0;
      y  = r0;
    end
    xpos = (xw != '0);
    cr   = xpos ? y - DIM_W'(1) : y - DIM_W'(2);
    ccw  = xpos ? xw - POS_W'(1) : width - POS_W'(1);
    crp1 = POS_W'(cr) + POS_W'(1);
    ccp1 = ccw + POS_W'(1);

    flags.emit   = (y >= DIM_W'(2)) || ((y == DIM_W'(1)) && xpos);
    flags.top    = (cr == '0);
    flags.bottom = (crp1 >= height);
    flags.left   = (ccw == '0);
    flags.right  = (ccp1 >= width);
    flags.last   = flags.emit && (crp1 == height) && (ccp1 == width);

    xn = xw + POS_W'(1);
    if (xn >= width) begin
      col_nxt = '0;
      row_nxt = y + DIM_W'(1);
    end else begin
      col_nxt = ADDR_W'(xn);
      row_nxt = y;
    end
    done_nxt = flags.last;
    x        = ADDR_W'(xw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      done_r <= 1'b0;
    end else if (adv) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// ----- rtl/bb3_window_sum.sv -----
module bb3_window_sum import bb3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_go,
  input  logic [PIX_W-1:0] up,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] pix,
  input  pos_flags_t       flags,
  output logic             in_ready,
  output logic             sum_valid,
  output sum_word_t        sum_word,
  input  logic             sum_ready
);

  logic [PIX_W-1:0] win_r [3][3];
  logic             s2_v_r;
  pos_flags_t       s2_flags_r;
  logic             s3_v_r;
  sum_word_t        s3_word_r, s3_nxt;

  logic             s3_free, s2_leave, s3_load;
  logic [2:0]       row_en, col_en;
  logic [1:0]       rc, cc;

  // handshake between window and sum stages
  assign s3_free  = !s3_v_r || sum_ready;
  assign s2_leave = s2_v_r && (!s2_flags_r.emit || s3_free);
  assign s3_load  = s2_v_r && s2_flags_r.emit && s3_free;
  assign in_ready = !s2_v_r || s2_leave;

  // 3x3 window shifts left, new column enters on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (in_go) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up;
      win_r[1][2] <= mid;
      win_r[2][2] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (in_go) begin
      s2_v_r <= 1'b1;
    end else if (s2_leave) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s2_flags_r <= flags;
    end
  end

  // masked sums over in-frame neighbors
  always_comb begin
    row_en = {!s2_flags_r.bottom, 1'b1, !s2_flags_r.top};
    col_en = {!s2_flags_r.right, 1'b1, !s2_flags_r.left};
    s3_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_en[r] && col_en[c]) begin
          s3_nxt.red   = s3_nxt.red   + SUM_W'(win_r[r][c][2*CHAN_W +: CHAN_W]);
          s3_nxt.green = s3_nxt.green + SUM_W'(win_r[r][c][CHAN_W +: CHAN_W]);
          s3_nxt.blue  = s3_nxt.blue  + SUM_W'(win_r[r][c][0 +: CHAN_W]);
        end
      end
    end
    rc = 2'd1 + 2'(row_en[0]) + 2'(row_en[2]);
    cc = 2'd1 + 2'(col_en[0]) + 2'(col_en[2]);
    s3_nxt.cnt  = CNT_W'(rc) * CNT_W'(cc);
    s3_nxt.pow2 = 2'd1 + 2'(rc == 2'd2) + 2'(cc == 2'd2);
    s3_nxt.pow3 = 2'(rc == 2'd3) + 2'(cc == 2'd3);
    s3_nxt.last = s2_flags_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_load) begin
      s3_v_r <= 1'b1;
    end else if (sum_ready) begin
      s3_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_word_r <= s3_nxt;
    end
  end

  assign sum_valid = s3_v_r;
  assign sum_word  = s3_word_r;

endmodule

// ----- rtl/bb3_mean.sv -----
module bb3_mean import bb3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  sum_word_t   in_word,
  output logic        in_ready,
  bb3_out_if.source   out_ch
);

  logic              out_v_r;
  logic [CHAN_W-1:0] red_r, green_r, blue_r;
  logic              last_r;
  logic              load;

  assign in_ready = !out_v_r || out_ch.ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  // rounded mean per channel into the result register
  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= round_mean(in_word.red,   in_word.cnt, in_word.pow2, in_word.pow3);
      green_r <= round_mean(in_word.green, in_word.cnt, in_word.pow2, in_word.pow3);
      blue_r  <= round_mean(in_word.blue,  in_word.cnt, in_word.pow2, in_word.pow3);
      last_r  <= in_word.last;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_red    = red_r;
  assign out_ch.out_green  = green_r;
  assign out_ch.out_blue   = blue_r;
  assign out_ch.last_pixel = last_r;

endmodule

// ----- rtl/box_blur_3x3_edge_aware.sv -----
// Results pass the input stage, window, sum and result registers; one word per cycle
// unless out_ch stalls. Each line store is read once and written once per word.
// A word with no result (first row plus one pixel) still moves through the window.
// Reset: synchronous, active-low rst_n; clears pipeline valids, position, window,
// and sets image_width to 640, image_height to 480. Line stores are not cleared.
module box_blur_3x3_edge_aware import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bb3_in_if.sink                in_ch,
  bb3_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int W_LIM  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int H_LIM  = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int ADDR_W = (W_LIM > 1) ? $clog2(W_LIM) : 1;

  logic [DIM_W-1:0]  width_r, height_r;
  logic [POS_W-1:0]  width_eff, height_eff;

  logic [ADDR_W-1:0] x_new;
  pos_flags_t        pos_flags;
  logic              in_acc;
  logic [PIX_W-1:0]  pix_new;

  logic              s1_v_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [ADDR_W-1:0] s1_x_r;
  pos_flags_t        s1_flags_r;
  logic              s1_byp_r, byp_nxt;
  logic [PIX_W-1:0]  s1_byp_up_r, s1_byp_mid_r;

  logic [PIX_W-1:0]  up_rd, mid_rd, up_eff, mid_eff;
  logic              win_ready, s1_go;

  logic              sum_valid, sum_ready;
  sum_word_t         sum_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        default:          ;
      endcase
    end
  end

  // zero counts as one, large values held at the maximum
  always_comb begin
    if (width_r == '0) begin
      width_eff = POS_W'(1);
    end else if (POS_W'(width_r) > POS_W'(W_LIM)) begin
      width_eff = POS_W'(W_LIM);
    end else begin
      width_eff = POS_W'(width_r);
    end
    if (height_r == '0) begin
      height_eff = POS_W'(1);
    end else if (POS_W'(height_r) > POS_W'(H_LIM)) begin
      height_eff = POS_W'(H_LIM);
    end else begin
      height_eff = POS_W'(height_r);
    end
  end

  // raster position of the incoming word
  bb3_raster #(.ADDR_W(ADDR_W)) u_raster (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (in_acc),
    .width  (width_eff),
    .height (height_eff),
    .x      (x_new),
    .flags  (pos_flags)
  );

  assign in_ch.ready = !s1_v_r || win_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_go       = s1_v_r && win_ready;
  assign pix_new     = (in_ch.func == FUNC_DRAIN) ? '0
                     : {in_ch.in_red, in_ch.in_green, in_ch.in_blue};

  // same column read while the previous word writes it (one-pixel rows)
  assign byp_nxt = s1_go && (s1_x_r == x_new);
  assign up_eff  = s1_byp_r ? s1_byp_up_r  : up_rd;
  assign mid_eff = s1_byp_r ? s1_byp_mid_r : mid_rd;

  // line stores: read at accept, write back when the word moves on
  bb3_ram #(.WIDTH(PIX_W), .DEPTH(W_LIM)) u_upper (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_x_r),
    .wdata (mid_eff),
    .re    (in_acc),
    .raddr (x_new),
    .rdata (up_rd)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(W_LIM)) u_middle (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_x_r),
    .wdata (s1_pix_r),
    .re    (in_acc),
    .raddr (x_new),
    .rdata (mid_rd)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_byp_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r   <= 1'b1;
      s1_byp_r <= byp_nxt;
    end else if (s1_go) begin
      s1_v_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r     <= pix_new;
      s1_x_r       <= x_new;
      s1_flags_r   <= pos_flags;
      s1_byp_up_r  <= mid_eff;
      s1_byp_mid_r <= s1_pix_r;
    end
  end

  bb3_window_sum u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_go     (s1_go),
    .up        (up_eff),
    .mid       (mid_eff),
    .pix       (s1_pix_r),
    .flags     (s1_flags_r),
    .in_ready  (win_ready),
    .sum_valid (sum_valid),
    .sum_word  (sum_word),
    .sum_ready (sum_ready)
  );

  bb3_mean u_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sum_valid),
    .in_word  (sum_word),
    .in_ready (sum_ready),
    .out_ch   (out_ch)
  );

  // accepted word lands in the input stage at its own column
  a_input_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r && (s1_x_r == $past(x_new)))
    else $error("input stage did not capture accepted word");

  // forwarded store data only ever serves the column just written
  a_bypass_col: assert property (@(posedge clk) disable iff (!rst_n)
    s1_byp_r |-> (s1_x_r == $past(s1_x_r)))
    else $error("line store forward used on a different column");

  // the frame's last word restarts the raster at column zero
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pos_flags.last) |=> (x_new == '0))
    else $error("raster did not restart after last pixel");

endmodule

// ----- tb/tb_box_blur_3x3_edge_aware.sv -----
`timescale 1ns / 100ps

module tb_box_blur_3x3_edge_aware;
  import bb3_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_WORDS  = 360;

  // one input word and one blurred pixel
  typedef struct {
    logic              func;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } in_word_t;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } blur_pix_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_STALLS} rdy_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bb3_in_if  in_if ();
  bb3_out_if out_if ();

  box_blur_3x3_edge_aware u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // stimulus words waiting to be sent, blurred pixels waiting to come out
  in_word_t  word_q[$];
  blur_pix_t blurred_q[$];

  int unsigned mismatches     = 0;
  int unsigned words_sent     = 0;
  int unsigned pixels_checked = 0;
  int unsigned frames_seen    = 0;
  logic        in_took        = 1'b0;

  logic [CHAN_W-1:0] pat [4] = '{8'h00, 8'hFF, 8'hAA, 8'h55};

  // ------------------------------------------------------------------
  // blur predictor state
  // ------------------------------------------------------------------
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [PIX_W-1:0] upper_line  [DEF_MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [DEF_MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      col_pos;
  logic [DIM_W-1:0] row_pos;
  bit               frame_done;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d, input int unsigned lim);
    if (d == '0) return 1;
    if (d > lim) return lim;
    return d;
  endfunction

  // advance the raster position by one word and queue the pixel it completes
  task automatic blur_step(input logic func, input logic [CHAN_W-1:0] r, g, b);
    int unsigned w, h, x, y, cr, cc, cnt, sr, sg, sb;
    logic [PIX_W-1:0] pix, up, mid, v;
    blur_pix_t res;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (frame_done) begin
      col_pos    = 0;
      row_pos    = '0;
      frame_done = 1'b0;
    end
    // width may have shrunk under the current column
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1'b1;
    end
    x = col_pos;
    y = row_pos;
    // drain ticks enter the window as black
    pix = (func == FUNC_PIXEL) ? {r, g, b} : '0;
    up  = upper_line[x];
    mid = middle_line[x];
    upper_line[x]  = mid;
    middle_line[x] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = pix;
    // center lags one row plus one pixel
    if (y >= 2 || (y == 1 && x >= 1)) begin
      cr  = (x >= 1) ? y - 1 : y - 2;
      cc  = (x >= 1) ? x - 1 : w - 1;
      sr  = 0;
      sg  = 0;
      sb  = 0;
      cnt = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (!(i == 0 && cr == 0) && !(i == 2 && cr + 1 >= h) &&
              !(j == 0 && cc == 0) && !(j == 2 && cc + 1 >= w)) begin
            v   = win[i][j];
            sr += v[23:16];
            sg += v[15:8];
            sb += v[7:0];
            cnt++;
          end
        end
      end
      // round half up: (2*sum + n) / (2*n)
      res.red   = CHAN_W'((2 * sr + cnt) / (2 * cnt));
      res.green = CHAN_W'((2 * sg + cnt) / (2 * cnt));
      res.blue  = CHAN_W'((2 * sb + cnt) / (2 * cnt));
      res.last  = (cr == h - 1 && cc == w - 1);
      if (res.last) frame_done = 1'b1;
      blurred_q.push_back(res);
    end
    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = DIM_W'(y + 1);
    end
  endtask

  // ------------------------------------------------------------------
  // predict on accepted words, check accepted pixels
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    blur_pix_t want;
    if (!rst_n) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      col_pos    = 0;
      row_pos    = '0;
      frame_done = 1'b0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          win[i][j] = '0;
      in_took <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_IMAGE_WIDTH:  width_reg = cfg_wdata;
          REG_IMAGE_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        words_sent++;
        blur_step(in_if.func, in_if.in_red, in_if.in_green, in_if.in_blue);
      end
      if (out_if.valid && out_if.ready) begin
        if (blurred_q.size() == 0) begin
          $error("unexpected blurred pixel r=%0d g=%0d b=%0d last=%0b",
                 out_if.out_red, out_if.out_green, out_if.out_blue, out_if.last_pixel);
          mismatches++;
        end else begin
          want = blurred_q.pop_front();
          pixels_checked++;
          if (out_if.out_red !== want.red) begin
            $error("out_red: expected %0d, actual %0d", want.red, out_if.out_red);
            mismatches++;
          end
          if (out_if.out_green !== want.green) begin
            $error("out_green: expected %0d, actual %0d", want.green, out_if.out_green);
            mismatches++;
          end
          if (out_if.out_blue !== want.blue) begin
            $error("out_blue: expected %0d, actual %0d", want.blue, out_if.out_blue);
            mismatches++;
          end
          if (out_if.last_pixel !== want.last) begin
            $error("last_pixel: expected %0b, actual %0b", want.last, out_if.last_pixel);
            mismatches++;
          end
          if (want.last) frames_seen++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // word driver: bursts with random gaps
  // ------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  in_word_t    nxt;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (gap_left > 0 || word_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        nxt = word_q.pop_front();
        in_if.func     <= nxt.func;
        in_if.in_red   <= nxt.red;
        in_if.in_green <= nxt.green;
        in_if.in_blue  <= nxt.blue;
        in_if.valid    <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // pixel receiver: stall mode changes every so often
  // ------------------------------------------------------------------
  rdy_mode_t   ready_mode = RDY_ALWAYS;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = rdy_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: out_if.ready <= 1'b1;
        RDY_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
          out_if.ready <= (stall_left == 0);
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_word(input logic func, input logic [CHAN_W-1:0] r, g, b);
    in_word_t wd;
    wd.func  = func;
    wd.red   = r;
    wd.green = g;
    wd.blue  = b;
    word_q.push_back(wd);
  endtask

  // one frame of w x h words plus w+1 drain ticks; odd_pct swaps some kinds
  task automatic push_frame(input int unsigned w, h, odd_pct);
    logic kind;
    for (int i = 0; i < w * h; i++) begin
      kind = ($urandom_range(0, 99) < odd_pct) ? FUNC_DRAIN : FUNC_PIXEL;
      push_word(kind, rand_chan(), rand_chan(), rand_chan());
    end
    for (int i = 0; i <= w; i++) begin
      kind = ($urandom_range(0, 99) < odd_pct) ? FUNC_PIXEL : FUNC_DRAIN;
      push_word(kind, rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  // all words sent, all pixels back, pipeline settled
  task automatic wait_idle();
    while (word_q.size() != 0 || in_if.valid) @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input int unsigned w_raw, h_raw);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_IMAGE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w_raw);
    @(negedge clk);
    cfg_idx   <= REG_IMAGE_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h_raw);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    int unsigned w_raw, h_raw, cur_w_raw, cur_h_raw, w, h, odd_pct, random_words;
    in_if.valid    = 1'b0;
    in_if.func     = FUNC_PIXEL;
    in_if.in_red   = '0;
    in_if.in_green = '0;
    in_if.in_blue  = '0;
    out_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_IMAGE_WIDTH;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x3: corners, edges and the center with bit-pattern extremes
    set_dims(3, 3);
    for (int k = 0; k < 9; k++)
      push_word(FUNC_PIXEL, pat[k % 4], pat[(k + 1) % 4], pat[(k + 2) % 4]);
    for (int k = 0; k < 4; k++)
      push_word(FUNC_DRAIN, pat[(k + 1) % 4], pat[k % 4], pat[(k + 3) % 4]);
    // back to back: early drain at the center, a pixel among the drain ticks
    for (int k = 0; k < 9; k++)
      push_word((k == 4) ? FUNC_DRAIN : FUNC_PIXEL,
                pat[(k + 3) % 4], pat[(k + 2) % 4], pat[k % 4]);
    for (int k = 0; k < 4; k++)
      push_word((k == 1) ? FUNC_PIXEL : FUNC_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    cur_w_raw = 3;
    cur_h_raw = 3;

    // random frames, mostly small, sometimes wide and flat
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       w_raw = 0;
          1:       w_raw = $urandom_range(20, 64);
          default: w_raw = $urandom_range(1, 10);
        endcase
        if (w_raw > 10) h_raw = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) h_raw = 0;
        else h_raw = $urandom_range(1, 8);
      end else begin
        w_raw = cur_w_raw;
        h_raw = cur_h_raw;
      end
      if (w_raw != cur_w_raw || h_raw != cur_h_raw) set_dims(w_raw, h_raw);
      cur_w_raw = w_raw;
      cur_h_raw = h_raw;
      w = (w_raw == 0) ? 1 : w_raw;
      h = (h_raw == 0) ? 1 : h_raw;
      odd_pct = ($urandom_range(0, 2) == 0) ? 10 : 0;
      push_frame(w, h, odd_pct);
      random_words += w * h + w + 1;
    end

    // register extremes: zero width and height both count as one
    set_dims(0, 0);
    push_frame(1, 1, 0);

    wait_idle();
    $display("%0d words sent, %0d blurred pixels checked, %0d frames completed",
             words_sent, pixels_checked, frames_seen);
    $display("frames from 1x1 up to 64 wide, zero sizes, early drains and late pixels");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- box_blur_3x3_edge_aware.f -----
rtl/bb3_pkg.sv
rtl/bb3_if.sv
rtl/bb3_ram.sv
rtl/bb3_raster.sv
rtl/bb3_window_sum.sv
rtl/bb3_mean.sv
rtl/box_blur_3x3_edge_aware.sv
tb/tb_box_blur_3x3_edge_aware.sv
